// ----- rtl/slri_pkg.sv -----
// shared types and constants for the sorted list insert/remove core
package slri_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic                      operation;
        logic signed [DATA_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic [ENTRY_W-1:0]        entry_count;
        logic signed [DATA_W-1:0]  smallest;
        logic                      smallest_valid;
    } t_out_item;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

endpackage

// ----- rtl/slri_cell.sv -----
// one slot of the sorted register chain
module slri_cell (
    input  logic                               i_clk,
    input  slri_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [slri_pkg::DATA_W-1:0] i_value,
    input  logic                               i_occupied,
    input  logic signed [slri_pkg::DATA_W-1:0] i_left_val,
    input  logic                               i_left_ge,
    input  logic signed [slri_pkg::DATA_W-1:0] i_right_val,
    output logic signed [slri_pkg::DATA_W-1:0] o_val,
    output logic                               o_ge,
    output logic                               o_eq
);
    import slri_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    assign o_val = r_val;
    assign o_ge  = i_occupied && (r_val >= i_value);
    assign o_eq  = i_occupied && (r_val == i_value);

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins_en) begin
            // left neighbor moving right, or the new value lands here
            if (i_left_ge) begin
                n_val = i_left_val;
            end else if (o_ge || !i_occupied) begin
                n_val = i_value;
            end
        end else if (i_ctrl.rem_en) begin
            // from the removed slot on, pull in the right neighbor
            if (o_ge) begin
                n_val = i_right_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- rtl/sorted_list_insert_remove_core.sv -----
// top level of the sorted list insert/remove core
// Holds up to CAPACITY signed 32-bit values in ascending order in a chain of
// identical register cells. Each input transaction either inserts its value
// in front of the first held entry that is greater or equal, or removes the
// first held entry equal to it; every cell compares itself against the
// incoming value at once and either keeps its value, takes the new value or
// takes a neighbor's value. Each input transaction yields exactly one output
// transaction carrying the status (done, not found, full), the entry count
// and the smallest entry (zero with smallest_valid low when empty). The
// result sits in an output register; a new input transaction is taken in
// the same cycle the pending result is taken, so the sustained rate is one
// transaction per cycle when the output side does not stall. Slots above
// the entry count are never read and need no clearing after reset.
module sorted_list_insert_remove_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  slri_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output slri_pkg::t_out_item o_out_data
);
    import slri_pkg::*;

    // chain wiring
    logic signed [DATA_W-1:0] w_val [CAPACITY];
    logic                     w_ge  [CAPACITY];
    logic [CAPACITY-1:0]      w_eq;
    t_cell_ctrl               w_ctrl;

    // control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [1:0]       n_status;

    logic accept;
    logic full;
    logic found;
    logic is_insert;

    // state may only change while no result is held back by a stall, since the
    // smallest entry is read live from the head cell
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_insert  = (i_in_data.operation == OP_INSERT);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign found      = |w_eq;

    assign w_ctrl.ins_en = accept && is_insert && !full;
    assign w_ctrl.rem_en = accept && !is_insert && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [DATA_W-1:0] left_val;
            logic                     left_ge;
            logic signed [DATA_W-1:0] right_val;

            if (gi == 0) begin : g_head
                assign left_val = '0;
                assign left_ge  = 1'b0;
            end else begin : g_mid
                assign left_val = w_val[gi-1];
                assign left_ge  = w_ge[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_val = '0;
            end else begin : g_body
                assign right_val = w_val[gi+1];
            end

            slri_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_value     (i_in_data.value),
                .i_occupied  (CNT_W'(gi) < r_count),
                .i_left_val  (left_val),
                .i_left_ge   (left_ge),
                .i_right_val (right_val),
                .o_val       (w_val[gi]),
                .o_ge        (w_ge[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    // status and next entry count
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (is_insert) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (found) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // status is payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    // result transaction, smallest comes straight from the head cell
    assign o_out_valid                = r_out_valid;
    assign o_out_data.status          = r_status;
    assign o_out_data.entry_count     = ENTRY_W'(r_count);
    assign o_out_data.smallest_valid  = (r_count != '0);
    assign o_out_data.smallest        = (r_count != '0) ? w_val[0] : '0;

endmodule

// ----- tb/tb_sorted_list_insert_remove_core.sv -----
// self-checking testbench for the sorted list insert/remove core
module tb_sorted_list_insert_remove_core;
    import slri_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_OPS  = 1330;
    localparam int PHASES      = 4;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    // tracks the list contents and the results still owed by the core
    class sorted_list_tracker;
        logic signed [DATA_W-1:0] held[$];
        t_out_item                awaited[$];
        int failures;
        int n_insert;
        int n_remove;
        int n_full;
        int n_miss;
        int peak;

        function void note_op(t_in_item op_in);
            t_out_item                want;
            logic signed [DATA_W-1:0] v;
            int                       pos;
            v   = op_in.value;
            pos = 0;
            if (op_in.operation == OP_INSERT) begin
                n_insert++;
                if (held.size() >= CAPACITY) begin
                    want.status = ST_FULL;
                    n_full++;
                end else begin
                    // new value goes in front of the first entry not below it
                    while (pos < held.size() && held[pos] < v) pos++;
                    held.insert(pos, v);
                    want.status = ST_DONE;
                end
            end else begin
                n_remove++;
                while (pos < held.size() && held[pos] != v) pos++;
                if (pos >= held.size()) begin
                    want.status = ST_NOT_FOUND;
                    n_miss++;
                end else begin
                    held.delete(pos);
                    want.status = ST_DONE;
                end
            end
            if (held.size() > peak) peak = held.size();
            want.entry_count    = ENTRY_W'(held.size());
            want.smallest       = (held.size() > 0) ? held[0] : '0;
            want.smallest_valid = (held.size() > 0);
            awaited.push_back(want);
        endfunction

        function void fail_note(string what, t_out_item want, t_out_item got);
            failures++;
            if (failures <= 10)
                $display("mismatch (%s): expected st=%0d cnt=%0d min=%0d v=%0b, %s",
                         what, want.status, want.entry_count, want.smallest,
                         want.smallest_valid,
                         $sformatf("got st=%0d cnt=%0d min=%0d v=%0b",
                                   got.status, got.entry_count,
                                   got.smallest, got.smallest_valid));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                fail_note("no result pending", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status != want.status || got.entry_count != want.entry_count ||
                got.smallest != want.smallest ||
                got.smallest_valid != want.smallest_valid)
                fail_note("field", want, got);
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    sorted_list_tracker tracker;
    int in_idle_pct;
    int out_stall_pct;
    int cycle_count;
    bit filling;

    sorted_list_insert_remove_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // receiver back-pressure, rate set per phase
    always @(posedge i_clk) begin
        i_out_stall <= (out_stall_pct > 0) && ($urandom_range(0, 99) < out_stall_pct);
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) tracker.note_op(i_in_data);
            if (o_out_valid && !i_out_stall) tracker.check_result(o_out_data);
        end
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_op(input t_op op, input logic signed [DATA_W-1:0] v);
        t_in_item op_in;
        int       gap;
        op_in.operation = op;
        op_in.value     = v;
        gap = 0;
        while ($urandom_range(0, 99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op_in;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_empty();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited.size() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return int'($urandom_range(0, 15)) - 8;
        if (sel < 55) begin
            case ($urandom_range(0, 3))
                0:       return MOST_NEG;
                1:       return MOST_NEG + 1;
                2:       return MOST_POS;
                default: return MOST_POS - 1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic random_op();
        int size;
        size = tracker.held.size();
        if (size >= CAPACITY) filling = 1'b0;
        if (size == 0) filling = 1'b1;
        // walk the fill level up and down so both full and empty are hit often
        if ($urandom_range(0, 99) < (filling ? 75 : 25))
            send_op(OP_INSERT, pick_value());
        else if (size > 0 && $urandom_range(0, 99) < 65)
            send_op(OP_REMOVE, tracker.held[$urandom_range(0, size - 1)]);
        else
            send_op(OP_REMOVE, pick_value());
    endtask

    initial begin
        int in_pct[PHASES];
        int out_pct[PHASES];
        in_pct        = '{0, 54, 0, 31};
        out_pct       = '{0, 0, 54, 31};
        tracker       = new();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        cycle_count   = 0;
        filling       = 1'b1;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_in_data     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, duplicates, absent values
        send_op(OP_REMOVE, 5);
        send_op(OP_INSERT, MOST_POS);
        send_op(OP_INSERT, MOST_NEG);
        send_op(OP_INSERT, 0);
        send_op(OP_INSERT, -1);
        send_op(OP_INSERT, 0);
        send_op(OP_REMOVE, 0);
        send_op(OP_REMOVE, 123);
        send_op(OP_REMOVE, MOST_NEG);
        // fill to capacity with descending values so each lands ahead of the one before
        for (int i = 0; i < CAPACITY - 3; i++) send_op(OP_INSERT, 1000 - i * 150);
        send_op(OP_INSERT, MOST_NEG);
        send_op(OP_REMOVE, MOST_POS);
        wait_empty();

        for (int p = 0; p < PHASES; p++) begin
            in_idle_pct   = in_pct[p];
            out_stall_pct = out_pct[p];
            for (int n = 0; n < RANDOM_OPS / PHASES; n++) begin
                random_op();
                // occasional pause mid-phase until the core has caught up
                if (n == RANDOM_OPS / (2 * PHASES)) wait_empty();
            end
            wait_empty();
        end
        repeat (4) @(posedge i_clk);

        if (tracker.awaited.size() != 0) begin
            tracker.failures += tracker.awaited.size();
            $display("%0d results never arrived", tracker.awaited.size());
        end
        $display("ran %0d inserts and %0d removes over %0d cycles", tracker.n_insert,
                 tracker.n_remove, cycle_count);
        $display("saw %0d full drops, %0d misses, fill level up to %0d, %0d failures",
                 tracker.n_full, tracker.n_miss, tracker.peak, tracker.failures);
        if (tracker.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/slri_pkg.sv
rtl/slri_cell.sv
rtl/sorted_list_insert_remove_core.sv
tb/tb_sorted_list_insert_remove_core.sv
